FILE: hw/rtl/ptbc_pkg.sv
// Shared types and constants for the point transform / bounding box center block.
// Used by ptbc_ctrl, ptbc_dp, the top level and the checker; no dependencies.
package ptbc_pkg;

    localparam int FRAC_BITS = 8;

    localparam int COORD_W = 16;
    localparam int OUT_W   = 24;
    localparam int SP_W    = 2 * COORD_W;
    localparam int PROD_W  = COORD_W + SP_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SH      = 2 * FRAC_BITS;
    localparam int AXES    = 3;

    localparam logic signed [ACC_W-1:0] ACC_RND =
        ACC_W'(SH > 0) << (SH - ((SH > 0) ? 1 : 0));
    localparam logic signed [ACC_W-1:0] ACC_OUT_MAX = ACC_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = ACC_W'(-(2 ** (OUT_W - 1)));
    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(-(2 ** (OUT_W - 1)));

    // configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 8;
    localparam int SCALE_W   = AXES * COORD_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALES = CFG_IDX_W'(3);
    localparam logic [SCALE_W-1:0]   SCALES_RST = SCALE_W'(48'h0100_0100_0100);

    // matrix row select
    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } t_in_beat;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic signed [OUT_W-1:0] out_z;
        logic signed [OUT_W-1:0] centre_x;
        logic signed [OUT_W-1:0] centre_y;
        logic signed [OUT_W-1:0] centre_z;
        logic                    centre_valid;
    } t_out_beat;

    typedef struct packed {
        logic       load;
        logic       scale;
        logic       mul_en;
        logic [1:0] row_mul;
        logic       sum_en;
        logic [1:0] row_sum;
        logic       track;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/ptbc_ctrl.sv
// Sequencer for the point transform block: issues datapath commands per item.
// Depends on ptbc_pkg (t_cmd, t_sts).
module ptbc_ctrl import ptbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_ROW   = 3'd2;
    localparam logic [2:0] ST_TRACK = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [1:0] STEP_FIRST = 2'd0;
    localparam logic [1:0] STEP_LAST  = 2'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_step      = STEP_FIRST;
                n_state     = ST_ROW;
            end
            ST_ROW: begin
                // multiply row k while summing row k-1
                o_cmd.mul_en  = (r_step != STEP_LAST);
                o_cmd.row_mul = r_step;
                o_cmd.sum_en  = (r_step != STEP_FIRST);
                o_cmd.row_sum = r_step - 2'd1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_TRACK;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            ST_TRACK: begin
                o_cmd.track = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_FIRST;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: hw/rtl/ptbc_dp.sv
// Datapath: config registers, scale and matrix multipliers, rounding and saturation,
// running extremes, center and the output register. Depends on ptbc_pkg.
module ptbc_dp import ptbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_beat             i_in_beat,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out_beat            o_out_beat
);

    logic [CFG_W-1:0]   r_row_x, r_row_y, r_row_z;
    logic [SCALE_W-1:0] r_scales;

    logic signed [COORD_W-1:0] r_pt   [AXES];
    logic                      r_last;
    logic signed [SP_W-1:0]    r_sp   [AXES];
    logic signed [PROD_W-1:0]  r_prod [AXES];
    logic signed [OUT_W-1:0]   r_t    [AXES];
    logic signed [OUT_W-1:0]   r_min  [AXES];
    logic signed [OUT_W-1:0]   r_max  [AXES];
    logic                      r_first;
    logic                      r_out_valid;
    t_out_beat                 r_out;

    logic [CFG_W-1:0]          w_row_mul, w_row_sum;
    logic signed [ACC_W-1:0]   w_acc, w_shr;
    logic signed [OUT_W-1:0]   w_sat;
    logic signed [OUT_W:0]     w_csum [AXES];
    logic signed [OUT_W-1:0]   w_cen  [AXES];

    // configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x  <= '0;
            r_row_y  <= '0;
            r_row_z  <= '0;
            r_scales <= SCALES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_X:  r_row_x  <= i_cfg_data;
                CFG_ROW_Y:  r_row_y  <= i_cfg_data;
                CFG_ROW_Z:  r_row_z  <= i_cfg_data;
                CFG_SCALES: r_scales <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.row_mul)
            ROW_X:   w_row_mul = r_row_x;
            ROW_Y:   w_row_mul = r_row_y;
            default: w_row_mul = r_row_z;
        endcase
        unique case (i_cmd.row_sum)
            ROW_X:   w_row_sum = r_row_x;
            ROW_Y:   w_row_sum = r_row_y;
            default: w_row_sum = r_row_z;
        endcase
    end

    // row sum: products, translation aligned to the product scale, round half up
    always_comb begin
        w_acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2])
              + (ACC_W'($signed(w_row_sum[4*COORD_W-1:3*COORD_W])) <<< SH)
              + ACC_RND;
        w_shr = w_acc >>> SH;
        if (w_shr > ACC_OUT_MAX) begin
            w_sat = OUT_MAX;
        end else if (w_shr < ACC_OUT_MIN) begin
            w_sat = OUT_MIN;
        end else begin
            w_sat = OUT_W'(w_shr);
        end
    end

    // center: exact sum, floor halve
    always_comb begin
        for (int j = 0; j < AXES; j++) begin
            w_csum[j] = (OUT_W + 1)'(r_min[j]) + (OUT_W + 1)'(r_max[j]);
            w_cen[j]  = w_csum[j][OUT_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt[0] <= i_in_beat.point_x;
            r_pt[1] <= i_in_beat.point_y;
            r_pt[2] <= i_in_beat.point_z;
            r_last  <= i_in_beat.last_point;
        end
        if (i_cmd.scale) begin
            for (int j = 0; j < AXES; j++) begin
                r_sp[j] <= r_pt[j] * $signed(r_scales[COORD_W*j +: COORD_W]);
            end
        end
        if (i_cmd.mul_en) begin
            for (int j = 0; j < AXES; j++) begin
                r_prod[j] <= $signed(w_row_mul[COORD_W*j +: COORD_W]) * r_sp[j];
            end
        end
        if (i_cmd.sum_en) begin
            unique case (i_cmd.row_sum)
                ROW_X:   r_t[0] <= w_sat;
                ROW_Y:   r_t[1] <= w_sat;
                default: r_t[2] <= w_sat;
            endcase
        end
        if (i_cmd.emit) begin
            r_out.out_x        <= r_t[0];
            r_out.out_y        <= r_t[1];
            r_out.out_z        <= r_t[2];
            r_out.centre_x     <= r_last ? w_cen[0] : '0;
            r_out.centre_y     <= r_last ? w_cen[1] : '0;
            r_out.centre_z     <= r_last ? w_cen[2] : '0;
            r_out.centre_valid <= r_last;
        end
    end

    // running extremes; first point of a box seeds them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < AXES; j++) begin
                r_min[j] <= '0;
                r_max[j] <= '0;
            end
            r_first <= 1'b1;
        end else if (i_cmd.track) begin
            for (int j = 0; j < AXES; j++) begin
                if (r_first || (r_t[j] < r_min[j])) begin
                    r_min[j] <= r_t[j];
                end
                if (r_first || (r_t[j] > r_max[j])) begin
                    r_max[j] <= r_t[j];
                end
            end
            r_first <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_beat     = r_out;

endmodule

FILE: hw/rtl/point_transform_bbox_center_core.sv
// Top level of the point transform / bounding box center block.
// Instantiates ptbc_ctrl and ptbc_dp; depends on ptbc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one base point
//   of a box per beat, signed Q8.8, with last_point marking the final point.
//   Output channel (o_out_valid / i_out_stall / o_out_beat) carries one beat per
//   point: the scaled and affine-transformed point in signed Q16.8, saturated.
//   The beat of the last point also carries the box center, (min + max) / 2 per
//   axis rounded toward minus infinity, with centre_valid set; the running
//   extremes then restart with the next point.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) writes one of the three matrix
//   rows or the axis scales per write; write only while the block is idle.
// Flow:
//   A point accepted in idle is loaded, then passes through per-axis scaling,
//   the row steps, in which the three rows pass through the three multipliers
//   with each row summed in the step after its products, an update of the
//   extremes and the load of the output register. The next point is accepted
//   only after the previous one has been loaded into the output register.
//   While a finished beat waits under i_out_stall, the next point is still
//   computed; it then holds in the sequencer until the output register frees up.
// Reset: scales go to 1.0, matrix rows to zero, box state clears, no beat valid.
module point_transform_bbox_center_core import ptbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_beat
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: one point at a time, stall input while busy
    ptbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic, box state and output register
    ptbc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_beat   (i_in_beat),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

FILE: hw/rtl/ptbc_chk.sv
// Port-level checker for point_transform_bbox_center_core, bound to the top level.
// Depends on ptbc_pkg (t_out_beat).
module ptbc_chk import ptbc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled output beat changed");

    // an accepted point keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again while busy");

    // no result appears right after a point is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after accept");

    // center fields are zero unless flagged
    a_centre_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.centre_valid) |->
        (o_out_beat.centre_x == '0 && o_out_beat.centre_y == '0
         && o_out_beat.centre_z == '0))
        else $error("center fields nonzero without centre_valid");

endmodule

bind point_transform_bbox_center_core ptbc_chk u_ptbc_chk (.*);
